FILE: hdl/trbs_pkg.sv
`timescale 1ns / 1ps

package trbs_pkg;

   // Servo pulse width bits, fixed by the port fields
   localparam int WIDTH_BITS = 12;
   localparam int HOLD_BITS  = 10;
   localparam int STEP_BITS  = 8;
   localparam int BRAKE_BITS = 8;
   localparam int PCT_BITS   = 8;
   localparam int MAG_BITS   = 7;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 12;

   // Truncating divide by 100 as multiply by a scaled reciprocal
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_BITS  = 20;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(((2 ** RECIP_SHIFT) + 99) / 100);
   localparam int SPAN_K_BITS = WIDTH_BITS + RECIP_BITS;
   localparam int PROD_BITS   = SPAN_K_BITS + MAG_BITS;

   localparam logic signed [PCT_BITS-1:0] PCT_MAX = 8'sd100;
   localparam logic signed [PCT_BITS-1:0] PCT_MIN = -8'sd100;

   typedef logic [WIDTH_BITS-1:0] width_type;
   typedef logic [HOLD_BITS-1:0]  hold_type;
   typedef logic [SPAN_K_BITS-1:0] span_k_type;

   typedef enum logic [1:0] {
      DIR_FWD  = 2'd0,
      DIR_REV  = 2'd1,
      DIR_STOP = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_RAMP_FINAL = 3'd1,
      PH_RAMP_BRAKE = 3'd2,
      PH_BRAKE_HOLD = 3'd3,
      PH_RAMP_IDLE  = 3'd4,
      PH_SETTLE     = 3'd5
   } phase_type;

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_BITS-1:0] REG_IDLE_WIDTH      = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FWD_MIN_WIDTH   = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FWD_MAX_WIDTH   = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REV_MIN_WIDTH   = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REV_MAX_WIDTH   = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_SIZE       = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_HOLD_TICKS = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BRAKE_PULSES    = 4'd7;

   typedef struct packed {
      width_type              idle_width;
      width_type              fwd_min_width;
      width_type              fwd_max_width;
      width_type              rev_min_width;
      width_type              rev_max_width;
      logic [STEP_BITS-1:0]   step_size;
      hold_type               step_hold_ticks;
      logic [BRAKE_BITS-1:0]  brake_pulses;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      idle_width:      12'd1500,
      fwd_min_width:   12'd1550,
      fwd_max_width:   12'd2000,
      rev_min_width:   12'd1450,
      rev_max_width:   12'd1000,
      step_size:       8'd10,
      step_hold_ticks: 10'd10,
      brake_pulses:    8'd3
   };

   typedef struct packed {
      width_type width;
      logic      rev;
   } map_res_type;

   typedef struct packed {
      width_type pulse_width;
      logic      busy_res;
      dir_type   motion_dir;
      logic      accepted;
   } rslt_type;

endpackage

FILE: hdl/trbs_if.sv
`timescale 1ns / 1ps

interface trbs_req_if import trbs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic signed [PCT_BITS-1:0]  percent;

   modport source (output valid, req_type, percent, input ready);
   modport sink (input valid, req_type, percent, output ready);
endinterface

interface trbs_rsp_if import trbs_pkg::*; ();
   logic       valid;
   logic       ready;
   width_type  pulse_width;
   logic       busy_res;
   logic [1:0] motion_dir;
   logic       accepted;

   modport source (output valid, pulse_width, busy_res, motion_dir, accepted, input ready);
   modport sink (input valid, pulse_width, busy_res, motion_dir, accepted, output ready);
endinterface

interface trbs_csr_if import trbs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: hdl/trbs_map.sv
`timescale 1ns / 1ps

module trbs_map import trbs_pkg::*; (
   input  logic                       clock,
   input  cfg_type                    cfg,
   input  logic signed [PCT_BITS-1:0] percent,
   output map_res_type                map_res
);

   logic signed [WIDTH_BITS:0]  span_fwd;
   logic signed [WIDTH_BITS:0]  span_rev;
   logic signed [WIDTH_BITS:0]  abs_fwd;
   logic signed [WIDTH_BITS:0]  abs_rev;
   span_k_type                  span_k_fwd_in;
   span_k_type                  span_k_rev_in;
   span_k_type                  span_k_fwd_ff;
   span_k_type                  span_k_rev_ff;
   logic                        neg_fwd_ff;
   logic                        neg_rev_ff;

   logic signed [PCT_BITS-1:0]  pct_clamp;
   logic signed [PCT_BITS-1:0]  pct_abs;
   logic [MAG_BITS-1:0]         mag;
   span_k_type                  span_k_sel;
   logic                        neg_sel;
   width_type                   base_sel;
   logic [PROD_BITS-1:0]        prod;
   width_type                   quot;

   // Span of each range, scaled by the reciprocal of 100; refreshed every cycle
   always_comb begin
      span_fwd = signed'({1'b0, cfg.fwd_max_width}) - signed'({1'b0, cfg.fwd_min_width});
      span_rev = signed'({1'b0, cfg.rev_max_width}) - signed'({1'b0, cfg.rev_min_width});
      abs_fwd  = span_fwd[WIDTH_BITS] ? -span_fwd : span_fwd;
      abs_rev  = span_rev[WIDTH_BITS] ? -span_rev : span_rev;
      span_k_fwd_in = {{RECIP_BITS{1'b0}}, abs_fwd[WIDTH_BITS-1:0]}
                      * {{WIDTH_BITS{1'b0}}, RECIP};
      span_k_rev_in = {{RECIP_BITS{1'b0}}, abs_rev[WIDTH_BITS-1:0]}
                      * {{WIDTH_BITS{1'b0}}, RECIP};
   end

   always_ff @(posedge clock) begin
      span_k_fwd_ff <= span_k_fwd_in;
      span_k_rev_ff <= span_k_rev_in;
      neg_fwd_ff    <= span_fwd[WIDTH_BITS];
      neg_rev_ff    <= span_rev[WIDTH_BITS];
   end

   always_comb begin
      if (percent > PCT_MAX) begin
         pct_clamp = PCT_MAX;
      end else if (percent < PCT_MIN) begin
         pct_clamp = PCT_MIN;
      end else begin
         pct_clamp = percent;
      end
      pct_abs = pct_clamp[PCT_BITS-1] ? -pct_clamp : pct_clamp;
      mag     = pct_abs[MAG_BITS-1:0];

      if (pct_clamp[PCT_BITS-1]) begin
         span_k_sel = span_k_rev_ff;
         neg_sel    = neg_rev_ff;
         base_sel   = cfg.rev_min_width;
      end else begin
         span_k_sel = span_k_fwd_ff;
         neg_sel    = neg_fwd_ff;
         base_sel   = cfg.fwd_min_width;
      end

      // Quotient truncates toward zero: divide the magnitude, then apply the sign
      prod = PROD_BITS'(mag) * PROD_BITS'(span_k_sel);
      quot = prod[RECIP_SHIFT +: WIDTH_BITS];

      map_res.rev = pct_clamp[PCT_BITS-1];
      if (pct_clamp == '0) begin
         map_res.width = cfg.idle_width;
      end else if (neg_sel) begin
         map_res.width = base_sel - quot;
      end else begin
         map_res.width = base_sel + quot;
      end
   end

endmodule

FILE: hdl/trbs_seq.sv
`timescale 1ns / 1ps

module trbs_seq import trbs_pkg::*; #(
   parameter int SETTLE_TICKS = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        cmd_item,
   input  map_res_type map_res,
   input  cfg_type     cfg,
   output rslt_type    rslt
);

   localparam hold_type SETTLE_HOLD = HOLD_BITS'(SETTLE_TICKS);

   typedef struct packed {
      width_type             cur;
      width_type             tgt;
      width_type             fin;
      dir_type               motion;
      phase_type             phase;
      hold_type              hold;
      logic [BRAKE_BITS-1:0] brake;
   } seq_state_type;

   seq_state_type st_ff;
   seq_state_type st_in;
   logic          acc;

   function automatic seq_state_type ramp_done(seq_state_type s, phase_type ph, cfg_type c);
      seq_state_type r;
      r = s;
      case (ph)
         PH_RAMP_BRAKE: begin
            r.phase = PH_BRAKE_HOLD;
            r.hold  = c.step_hold_ticks;
         end
         PH_RAMP_IDLE: begin
            r.phase = PH_SETTLE;
            r.hold  = SETTLE_HOLD;
         end
         default: begin
            r.phase = PH_IDLE;
            if (r.motion == DIR_STOP) begin
               r.motion = DIR_REV;
            end
         end
      endcase
      return r;
   endfunction

   // Jump at once if already there or never driven, else start stepping
   function automatic seq_state_type begin_ramp(seq_state_type s, width_type tgt,
                                                phase_type ph, cfg_type c);
      seq_state_type r;
      r     = s;
      r.tgt = tgt;
      if (tgt == s.cur || s.cur == '0) begin
         r.cur = tgt;
         r     = ramp_done(r, ph, c);
      end else begin
         r.phase = ph;
         r.hold  = c.step_hold_ticks;
      end
      return r;
   endfunction

   function automatic seq_state_type expire(seq_state_type s, cfg_type c);
      seq_state_type          r;
      logic [STEP_BITS-1:0]   step;
      logic [WIDTH_BITS:0]    cur_x;
      logic [WIDTH_BITS:0]    tgt_x;
      logic [WIDTH_BITS:0]    step_x;
      r      = s;
      step   = (c.step_size == '0) ? STEP_BITS'(1) : c.step_size;
      cur_x  = {1'b0, s.cur};
      tgt_x  = {1'b0, s.tgt};
      step_x = (WIDTH_BITS + 1)'(step);
      case (s.phase) inside
         PH_RAMP_FINAL, PH_RAMP_BRAKE, PH_RAMP_IDLE: begin
            if (s.cur > s.tgt && cur_x > tgt_x + step_x) begin
               r.cur  = s.cur - WIDTH_BITS'(step);
               r.hold = c.step_hold_ticks;
            end else if (s.cur <= s.tgt && cur_x + step_x < tgt_x) begin
               r.cur  = s.cur + WIDTH_BITS'(step);
               r.hold = c.step_hold_ticks;
            end else begin
               r.cur = s.tgt;
               r     = ramp_done(r, s.phase, c);
            end
         end
         PH_BRAKE_HOLD: begin
            if (s.brake > BRAKE_BITS'(1)) begin
               r.brake = s.brake - BRAKE_BITS'(1);
               r.hold  = c.step_hold_ticks;
            end else begin
               r.brake = '0;
               r       = begin_ramp(r, c.idle_width, PH_RAMP_IDLE, c);
            end
         end
         PH_SETTLE: begin
            r = begin_ramp(r, s.fin, PH_RAMP_FINAL, c);
         end
         default: begin
            r.phase = PH_IDLE;
         end
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.cur    <= '0;
         st_ff.tgt    <= '0;
         st_ff.fin    <= '0;
         st_ff.motion <= DIR_FWD;
         st_ff.phase  <= PH_IDLE;
         st_ff.hold   <= '0;
         st_ff.brake  <= '0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      st_in = st_ff;
      acc   = 1'b0;
      if (advance) begin
         if (!cmd_item) begin
            if (st_ff.phase != PH_IDLE) begin
               if (st_ff.hold > HOLD_BITS'(1)) begin
                  st_in.hold = st_ff.hold - HOLD_BITS'(1);
               end else begin
                  st_in = expire(st_ff, cfg);
               end
            end
         end else if (st_ff.phase == PH_IDLE) begin
            acc       = 1'b1;
            st_in.fin = map_res.width;
            if (st_ff.motion == DIR_FWD && map_res.rev) begin
               st_in.motion = DIR_STOP;
               st_in.brake  = cfg.brake_pulses;
               if (cfg.brake_pulses == '0) begin
                  st_in = begin_ramp(st_in, cfg.idle_width, PH_RAMP_IDLE, cfg);
               end else begin
                  st_in = begin_ramp(st_in, cfg.rev_max_width, PH_RAMP_BRAKE, cfg);
               end
            end else begin
               st_in.motion = map_res.rev ? DIR_REV : DIR_FWD;
               st_in        = begin_ramp(st_in, map_res.width, PH_RAMP_FINAL, cfg);
            end
         end
      end
      rslt.pulse_width = st_in.cur;
      rslt.busy_res    = (st_in.phase != PH_IDLE);
      rslt.motion_dir  = st_in.motion;
      rslt.accepted    = acc;
   end

endmodule

FILE: hdl/throttle_ramp_brake_sequencer.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake       Payload
// req_chan  in   valid / ready   req_type (0 tick, 1 command), percent (signed 8)
// rsp_chan  out  valid / ready   pulse_width, busy_res, motion_dir, accepted
// csr_chan  in   valid / ready   index (register 0..7), wdata
//
// One request per clock while rsp_chan is not stalled and csr_chan.valid is low.
// A taken request is held in the input register and its response in the response
// register, around the single-pass sequencer logic; the percent map uses one 7x32 multiply.
// Reset is synchronous; req_chan.ready and csr_chan.ready are low while reset is high.
// A request is not taken in a cycle where csr_chan.valid is high.
// A stalled response holds in its register while the next request waits in the input one.

module throttle_ramp_brake_sequencer import trbs_pkg::*; #(
   parameter int SETTLE_TICKS = 100
) (
   input  logic    clock,
   input  logic    reset,
   trbs_req_if.sink   req_chan,
   trbs_rsp_if.source rsp_chan,
   trbs_csr_if.sink   csr_chan
);

   cfg_type                     cfg_ff;
   cfg_type                     cfg_in;
   logic                        csr_fire;

   logic                        in_valid_ff;
   logic                        in_type_ff;
   logic signed [PCT_BITS-1:0]  in_pct_ff;
   logic                        req_fire;
   logic                        advance;

   logic                        out_valid_ff;
   rslt_type                    rsp_ff;
   rslt_type                    rsp_in;
   map_res_type                 map_res;

   // Configuration registers: ready outside reset, unknown indexes drop the write
   assign csr_chan.ready = !reset;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         unique case (csr_chan.index)
            REG_IDLE_WIDTH:      cfg_in.idle_width      = csr_chan.wdata[WIDTH_BITS-1:0];
            REG_FWD_MIN_WIDTH:   cfg_in.fwd_min_width   = csr_chan.wdata[WIDTH_BITS-1:0];
            REG_FWD_MAX_WIDTH:   cfg_in.fwd_max_width   = csr_chan.wdata[WIDTH_BITS-1:0];
            REG_REV_MIN_WIDTH:   cfg_in.rev_min_width   = csr_chan.wdata[WIDTH_BITS-1:0];
            REG_REV_MAX_WIDTH:   cfg_in.rev_max_width   = csr_chan.wdata[WIDTH_BITS-1:0];
            REG_STEP_SIZE:       cfg_in.step_size       = csr_chan.wdata[STEP_BITS-1:0];
            REG_STEP_HOLD_TICKS: cfg_in.step_hold_ticks = csr_chan.wdata[HOLD_BITS-1:0];
            REG_BRAKE_PULSES:    cfg_in.brake_pulses    = csr_chan.wdata[BRAKE_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance the held request when the response register is free or draining.
   // Hold off requests during a csr write so the registered span products
   // are fresh when that request is worked on.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && !csr_chan.valid && (!in_valid_ff || advance);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff <= req_chan.req_type;
         in_pct_ff  <= req_chan.percent;
      end
   end

   // Map percent into the forward or reverse pulse range, or zero to the idle width
   trbs_map u_map (
      .clock   (clock),
      .cfg     (cfg_ff),
      .percent (in_pct_ff),
      .map_res (map_res)
   );

   // Ramp, brake and settle sequencing; state moves once per advanced request
   trbs_seq #(
      .SETTLE_TICKS (SETTLE_TICKS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cmd_item (in_type_ff),
      .map_res  (map_res),
      .cfg      (cfg_ff),
      .rslt     (rsp_in)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pulse_width = rsp_ff.pulse_width;
   assign rsp_chan.busy_res    = rsp_ff.busy_res;
   assign rsp_chan.motion_dir  = rsp_ff.motion_dir;
   assign rsp_chan.accepted    = rsp_ff.accepted;

`ifndef ASSERT_OFF
   // A tick never reports a taken command
   a_tick_not_accepted: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_type_ff) |=> !rsp_ff.accepted)
      else $error("tick request reported as accepted command");

   // Once the sequence ends, the brake direction has resolved to reverse
   a_idle_not_stopped: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ff.busy_res) |-> (rsp_ff.motion_dir != DIR_STOP))
      else $error("idle response still shows stopped direction");

   // A request is never taken together with a csr write
   a_req_csr_apart: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !csr_fire)
      else $error("request taken during csr write");

   // Every advanced request lands in the response register
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request produced no response");
`endif

endmodule
